FILE: hdl/lcta_pkg.sv
// ----------------------------------------------------------------------------
// lcta_pkg
// Shared types, widths and constants of the load cell converter reader.
// ----------------------------------------------------------------------------
package lcta_pkg;

  localparam int unsigned ROUNDS_DEF      = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned HALF_W     = 10;
  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned DIVR_W     = 16;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned WEIGHT_W   = 24;
  localparam int unsigned BIT_CNT_W  = 5;
  localparam int unsigned GOOD_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;

  // shared divider: SUM_W-bit dividend, DIVR_W-bit divisor, one bit a cycle
  localparam int unsigned DIV_W     = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam logic [HALF_W-1:0]    HALF_PERIOD_RST = HALF_W'(100);
  localparam logic [HALF_W-1:0]    TRAIL_RST       = HALF_W'(20);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = TIMEOUT_W'(150000);
  localparam logic [DIVR_W-1:0]    DIVIDER_RST     = DIVR_W'(80);
  localparam logic [SUM_W-1:0]     SUM_OFFSET_RST  = SUM_W'(5000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_OFFSET  = 3'd4;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HIGH,
    PH_LOW,
    PH_TRAIL_HIGH,
    PH_TRAIL_LOW
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_SAMPLE,
    ST_ACCUM,
    ST_DIV_AVG,
    ST_PUSH
  } ctrl_state_e;

  typedef enum logic {
    DIV_SEL_SAMPLE,
    DIV_SEL_AVG
  } div_sel_e;

  typedef struct packed {
    logic data_pin;
    logic tare_request;
  } in_t;

  typedef struct packed {
    logic                clock_pin;
    logic                weight_valid;
    logic [WEIGHT_W-1:0] weight;
    logic                tare_done;
    logic                timed_out;
  } out_t;

  typedef struct packed {
    logic     latch;
    logic     tick;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_q;
    logic     accum;
    logic     store_avg;
    logic     push;
  } cmd_t;

  typedef struct packed {
    logic conv_end;
    logic tare_mode;
    logic div_done;
    logic round_done;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/lcta_div.sv
// ----------------------------------------------------------------------------
// lcta_div
// Restoring divider, one quotient bit per cycle, shared by the per-sample
// scaling and the final average.
// ----------------------------------------------------------------------------
module lcta_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lcta_pkg::DIV_W-1:0]  dividend_i,
  input  logic [lcta_pkg::DIVR_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [lcta_pkg::DIV_W-1:0]  quotient_o
);
  import lcta_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     num_q, num_d;
  logic [DIVR_W-1:0]    den_q;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIVR_W:0]      rem_sh;
  logic                 ge;
  logic                 last;

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? DIVR_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIVR_W-1:0];
    num_d  = {num_q[DIV_W-2:0], ge};
    last   = cnt_q == DIV_CNT_W'(DIV_W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= dividend_i;
        den_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

FILE: hdl/lcta_datapath.sv
// ----------------------------------------------------------------------------
// lcta_datapath
// Configuration registers, serial clock phase machine, tare correction,
// sample accumulation and the output register.
// ----------------------------------------------------------------------------
module lcta_datapath #(
  parameter int unsigned ROUNDS      = lcta_pkg::ROUNDS_DEF,
  parameter int unsigned SAMPLE_BITS = lcta_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcta_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  lcta_pkg::in_t                  in_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output lcta_pkg::out_t                 out_data_o,
  input  lcta_pkg::cmd_t                 cmd_i,
  output lcta_pkg::stat_t                stat_o
);
  import lcta_pkg::*;

  // configuration
  logic [HALF_W-1:0]    half_q, trail_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [DIVR_W-1:0]    divider_q;
  logic [SUM_W-1:0]     offset_q;

  // converter read state
  phase_e                 phase_q, phase_d;
  logic [TIMEOUT_W-1:0]   tick_q, tick_d;
  logic [BIT_CNT_W-1:0]   bit_q, bit_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic                   din_q;

  // averaging state
  logic [WEIGHT_W-1:0] v_q;
  logic [SUM_W-1:0]    sum_q;
  logic [GOOD_W-1:0]   good_q;
  logic [WEIGHT_W-1:0] tare_base_q;
  logic                tare_mode_q;
  logic                pending_q;

  out_t res_q;
  out_t out_q;
  logic out_valid_q;

  logic [TIMEOUT_W-1:0]   tick_inc;
  logic [HALF_W-1:0]      lim_raw, lim;
  logic                   half_done;
  logic [BIT_CNT_W-1:0]   bit_inc;
  logic                   clk_c, tout_c, conv_end_c;
  logic [SAMPLE_BITS-1:0] raw_s;
  logic [WEIGHT_W-1:0]    raw, diff;
  logic [SUM_W-1:0]       sum_new, avg_num;
  logic [GOOD_W-1:0]      good_new;
  logic                   v_nz, round_done;
  logic [DIVR_W-1:0]      div_den;
  logic [DIV_W-1:0]       div_num, div_quo;
  logic                   div_done;

  // one tick of the serial read
  always_comb begin
    tick_inc   = tick_q + 1'b1;
    lim_raw    = (phase_q == PH_HIGH || phase_q == PH_LOW) ? half_q : trail_q;
    lim        = (lim_raw == '0) ? HALF_W'(1) : lim_raw;
    half_done  = tick_inc >= TIMEOUT_W'(lim);
    bit_inc    = bit_q + 1'b1;
    phase_d    = phase_q;
    tick_d     = tick_inc;
    bit_d      = bit_q;
    shift_d    = shift_q;
    clk_c      = 1'b0;
    tout_c     = 1'b0;
    conv_end_c = 1'b0;
    case (phase_q)
      PH_WAIT: begin
        if (!din_q) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
          bit_d   = '0;
          shift_d = '0;
        end else if (tick_inc >= timeout_q) begin
          tick_d = '0;
          tout_c = 1'b1;
        end
      end
      PH_HIGH: begin
        clk_c = 1'b1;
        if (half_done) begin
          tick_d  = '0;
          phase_d = PH_LOW;
        end
      end
      PH_LOW: begin
        if (half_done) begin
          tick_d  = '0;
          shift_d = {shift_q[SAMPLE_BITS-2:0], din_q};
          bit_d   = bit_inc;
          phase_d = (bit_inc >= BIT_CNT_W'(SAMPLE_BITS)) ? PH_TRAIL_HIGH : PH_HIGH;
        end
      end
      PH_TRAIL_HIGH: begin
        clk_c = 1'b1;
        if (half_done) begin
          tick_d  = '0;
          phase_d = PH_TRAIL_LOW;
        end
      end
      PH_TRAIL_LOW: begin
        if (half_done) begin
          tick_d     = '0;
          phase_d    = PH_WAIT;
          conv_end_c = 1'b1;
        end
      end
      default: begin
        phase_d = PH_WAIT;
        tick_d  = '0;
      end
    endcase
  end

  // sign flip to offset binary, then tare correction
  always_comb begin
    raw_s = shift_q ^ (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1));
    raw   = WEIGHT_W'(raw_s);
    diff  = (raw < tare_base_q) ? '0 : raw - tare_base_q;
  end

  always_comb begin
    v_nz       = v_q != '0;
    sum_new    = sum_q + SUM_W'(v_q);
    good_new   = good_q + 1'b1;
    round_done = v_nz && (good_new >= GOOD_W'(ROUNDS));
    if (tare_mode_q) begin
      avg_num = sum_new;
    end else begin
      avg_num = (sum_new <= offset_q) ? '0 : sum_new - offset_q;
    end
    if (cmd_i.div_sel == DIV_SEL_AVG) begin
      div_num = avg_num;
      div_den = DIVR_W'(ROUNDS);
    end else begin
      div_num = DIV_W'(diff);
      div_den = (divider_q == '0) ? DIVR_W'(1) : divider_q;
    end
  end

  lcta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= HALF_PERIOD_RST;
      trail_q   <= TRAIL_RST;
      timeout_q <= TIMEOUT_RST;
      divider_q <= DIVIDER_RST;
      offset_q  <= SUM_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_PERIOD: half_q    <= cfg_wdata_i[HALF_W-1:0];
        CFG_TRAIL:       trail_q   <= cfg_wdata_i[HALF_W-1:0];
        CFG_TIMEOUT:     timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_DIVIDER:     divider_q <= cfg_wdata_i[DIVR_W-1:0];
        CFG_SUM_OFFSET:  offset_q  <= cfg_wdata_i[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      din_q       <= 1'b1;
      v_q         <= '0;
      sum_q       <= '0;
      good_q      <= '0;
      tare_base_q <= '0;
      tare_mode_q <= 1'b0;
      pending_q   <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cmd_i.latch) begin
        din_q <= in_data_i.data_pin;
        if (in_data_i.tare_request) begin
          pending_q <= 1'b1;
        end
      end
      if (cmd_i.tick) begin
        phase_q            <= phase_d;
        tick_q             <= tick_d;
        bit_q              <= bit_d;
        shift_q            <= shift_d;
        res_q.clock_pin    <= clk_c;
        res_q.timed_out    <= tout_c;
        res_q.weight_valid <= 1'b0;
        res_q.tare_done    <= 1'b0;
        res_q.weight       <= '0;
        if (conv_end_c) begin
          v_q <= tare_mode_q ? raw : diff;
        end
      end
      if (cmd_i.load_q) begin
        v_q <= div_quo[WEIGHT_W-1:0];
      end
      if (cmd_i.accum && v_nz) begin
        if (round_done) begin
          sum_q              <= '0;
          good_q             <= '0;
          res_q.weight_valid <= !tare_mode_q;
          res_q.tare_done    <= tare_mode_q;
          tare_mode_q        <= pending_q;
          pending_q          <= 1'b0;
        end else begin
          sum_q  <= sum_new;
          good_q <= good_new;
        end
      end
      if (cmd_i.store_avg) begin
        if (res_q.tare_done) begin
          tare_base_q <= div_quo[WEIGHT_W-1:0];
        end else begin
          res_q.weight <= div_quo[WEIGHT_W-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
      out_q       <= res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.conv_end   = conv_end_c;
  assign stat_o.tare_mode  = tare_mode_q;
  assign stat_o.div_done   = div_done;
  assign stat_o.round_done = round_done;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

FILE: hdl/lcta_ctrl.sv
// ----------------------------------------------------------------------------
// lcta_ctrl
// Sequencer: takes one tick, steps the read, runs the divisions and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module lcta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lcta_pkg::stat_t stat_i,
  output lcta_pkg::cmd_t  cmd_o
);
  import lcta_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stat_i.conv_end) begin
          state_d = ST_PUSH;
        end else if (stat_i.tare_mode) begin
          state_d = ST_ACCUM;
        end else begin
          state_d = ST_DIV_SAMPLE;
        end
      end
      ST_DIV_SAMPLE: begin
        if (stat_i.div_done) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_d = stat_i.round_done ? ST_DIV_AVG : ST_PUSH;
      end
      ST_DIV_AVG: begin
        if (stat_i.div_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.tick      = 1'b1;
        cmd_o.div_sel   = DIV_SEL_SAMPLE;
        cmd_o.div_start = stat_i.conv_end && !stat_i.tare_mode;
      end
      ST_DIV_SAMPLE: begin
        cmd_o.load_q = stat_i.div_done;
      end
      ST_ACCUM: begin
        cmd_o.accum     = 1'b1;
        cmd_o.div_sel   = DIV_SEL_AVG;
        cmd_o.div_start = stat_i.round_done;
      end
      ST_DIV_AVG: begin
        cmd_o.div_sel   = DIV_SEL_AVG;
        cmd_o.store_avg = stat_i.div_done;
      end
      ST_PUSH: begin
        cmd_o.push = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/load_cell_adc_tare_averager_core.sv
// ----------------------------------------------------------------------------
// load_cell_adc_tare_averager_core
// Tick-driven serial reader for a 24-bit bridge converter with tare
// subtraction and averaging.
// ----------------------------------------------------------------------------
// Each input beat is one tick: the sampled data/ready line and a tare request.
// Each tick returns exactly one output beat with the serial clock level and
// the status flags. Ticks are processed one at a time. An ordinary tick
// passes through the accept, evaluate and push states. Its output beat is
// registered by the push, and the next beat is accepted only after it. The
// shared bit-serial divider produces 28 quotient bits and then raises done.
// The tick that ends a conversion adds the accumulate state, plus a sample
// divide in measure mode. When that sample completes an average, the average
// divide follows before the push. A stalled output holds the push state.
// ----------------------------------------------------------------------------
module load_cell_adc_tare_averager_core #(
  parameter int unsigned ROUNDS      = lcta_pkg::ROUNDS_DEF,
  parameter int unsigned SAMPLE_BITS = lcta_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcta_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lcta_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lcta_pkg::out_t                 out_data_o
);
  import lcta_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lcta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcta_datapath #(
    .ROUNDS      (ROUNDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: hdl/lcta_chk.sv
// ----------------------------------------------------------------------------
// lcta_chk
// Port-level checks of the converter reader, bound to the top level.
// ----------------------------------------------------------------------------
module lcta_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input lcta_pkg::out_t out_data_i
);

  // weight is only nonzero on a beat that carries a new average
  a_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.weight_valid |-> out_data_i.weight == '0)
    else $error("weight nonzero without weight_valid");

  // an average is either a weight or a tare, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_data_i.weight_valid && out_data_i.tare_done))
    else $error("weight_valid and tare_done together");

  // averages complete at the end of the trailing low half, clock is low
  a_avg_clk_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.weight_valid || out_data_i.tare_done)
      |-> !out_data_i.clock_pin && !out_data_i.timed_out)
    else $error("average reported outside trailing low half");

  // a timeout only happens while waiting, clock is low
  a_timeout_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.timed_out |-> !out_data_i.clock_pin)
    else $error("timeout with clock high");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled output beat changed");

endmodule

bind load_cell_adc_tare_averager_core lcta_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

FILE: tb/tb_load_cell_adc_tare_averager_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_load_cell_adc_tare_averager_core
// Drives one converter tick per input beat and follows the bridge converter
// protocol: data-ready waits, timeouts, 24-bit serial reads, tare requests.
// A tick-level predictor runs beside the core and every output beat is
// compared field by field, across several register settings and
// handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_load_cell_adc_tare_averager_core;
  import lcta_pkg::*;

  localparam int SETTLE_CYCLES = 80;     // above the worst per-tick latency
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEMS_TARGET  = 1800;
  localparam int ITEMS_CAP     = 4500;
  localparam longint RUN_LIMIT_NS = 40_000_000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Tick-level model of the reader plus the queue of output beats still owed.
  class tare_avg_scoreboard;
    logic [HALF_W-1:0]    half_ticks, trail_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [DIVR_W-1:0]    divider;
    logic [SUM_W-1:0]     offset;

    phase_e                      phase;
    logic [TIMEOUT_W-1:0]        tick_cnt;
    logic [BIT_CNT_W-1:0]        bit_cnt;
    logic [WEIGHT_W-1:0]         shift_word;
    logic [SUM_W-1:0]            sample_acc;
    logic [GOOD_W-1:0]           good_cnt;
    logic [WEIGHT_W-1:0]         tare_base;
    bit                          tare_mode, tare_pending;

    out_t expected_q[$];
    int errors, ticks_seen, conversions, weights, tares, timeouts;

    function new();
      half_ticks    = HALF_PERIOD_RST;
      trail_ticks   = TRAIL_RST;
      timeout_ticks = TIMEOUT_RST;
      divider       = DIVIDER_RST;
      offset        = SUM_OFFSET_RST;
      phase         = PH_WAIT;
      tick_cnt      = '0;
      bit_cnt       = '0;
      shift_word    = '0;
      sample_acc    = '0;
      good_cnt      = '0;
      tare_base     = '0;
      tare_mode     = 1'b0;
      tare_pending  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HALF_PERIOD: half_ticks    = val[HALF_W-1:0];
        CFG_TRAIL:       trail_ticks   = val[HALF_W-1:0];
        CFG_TIMEOUT:     timeout_ticks = val[TIMEOUT_W-1:0];
        CFG_DIVIDER:     divider       = val[DIVR_W-1:0];
        CFG_SUM_OFFSET:  offset        = val[SUM_W-1:0];
        default: ;
      endcase
    endfunction

    // counts one tick of a clock half; a limit of zero behaves as one
    function bit half_over(logic [HALF_W-1:0] limit);
      logic [HALF_W-1:0] lim;
      lim = (limit == '0) ? HALF_W'(1) : limit;
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= lim) begin
        tick_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(in_t beat);
      out_t r;
      logic [WEIGHT_W-1:0] raw, v;
      logic [DIVR_W-1:0]   d;
      r = '0;
      ticks_seen++;
      if (beat.tare_request) tare_pending = 1'b1;
      case (phase)
        PH_WAIT: begin
          if (!beat.data_pin) begin
            phase      = PH_HIGH;
            tick_cnt   = '0;
            bit_cnt    = '0;
            shift_word = '0;
          end else begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= timeout_ticks) begin
              tick_cnt    = '0;
              r.timed_out = 1'b1;
              timeouts++;
            end
          end
        end
        PH_HIGH: begin
          r.clock_pin = 1'b1;
          if (half_over(half_ticks)) phase = PH_LOW;
        end
        PH_LOW: begin
          if (half_over(half_ticks)) begin
            shift_word = {shift_word[WEIGHT_W-2:0], beat.data_pin};
            bit_cnt    = bit_cnt + 1'b1;
            phase      = (bit_cnt >= SAMPLE_BITS_DEF) ? PH_TRAIL_HIGH : PH_HIGH;
          end
        end
        PH_TRAIL_HIGH: begin
          r.clock_pin = 1'b1;
          if (half_over(trail_ticks)) phase = PH_TRAIL_LOW;
        end
        PH_TRAIL_LOW: begin
          if (half_over(trail_ticks)) begin
            conversions++;
            // two's complement to offset binary
            raw      = shift_word ^ (WEIGHT_W'(1) << (SAMPLE_BITS_DEF - 1));
            phase    = PH_WAIT;
            tick_cnt = '0;
            if (tare_mode) begin
              v = raw;
            end else begin
              d = (divider == '0) ? DIVR_W'(1) : divider;
              v = (raw < tare_base) ? '0 : (raw - tare_base) / d;
            end
            if (v != '0) begin
              sample_acc = sample_acc + v;
              good_cnt   = good_cnt + 1'b1;
              if (good_cnt >= ROUNDS_DEF) begin
                if (tare_mode) begin
                  tare_base   = WEIGHT_W'(sample_acc / ROUNDS_DEF);
                  r.tare_done = 1'b1;
                  tares++;
                end else begin
                  r.weight_valid = 1'b1;
                  r.weight = (sample_acc <= offset) ? '0 :
                             WEIGHT_W'((sample_acc - offset) / ROUNDS_DEF);
                  weights++;
                end
                sample_acc   = '0;
                good_cnt     = '0;
                tare_mode    = tare_pending;
                tare_pending = 1'b0;
              end
            end
          end
        end
        default: begin
          phase    = PH_WAIT;
          tick_cnt = '0;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void compare_field(string nm, int unsigned e, int unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      end
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: output beat with none expected, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("clock_pin", e.clock_pin, got.clock_pin);
      compare_field("weight_valid", e.weight_valid, got.weight_valid);
      compare_field("weight", e.weight, got.weight);
      compare_field("tare_done", e.tare_done, got.tare_done);
      compare_field("timed_out", e.timed_out, got.timed_out);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;

  tare_avg_scoreboard sb;
  idle_mode_e         idle_mode;
  bit                 hold_off;
  int                 items_sent;
  int                 settings_used;
  logic [WEIGHT_W-1:0] conv_word;   // word the converter model shifts out
  int                 wait_left;    // data-ready delay before the next conversion

  load_cell_adc_tare_averager_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d output beats outstanding", sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side: random stall, plus one long hold-off on request
  initial begin
    int pct;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      pct = (idle_mode == IDLE_RECV) ? 82 : (idle_mode == IDLE_BOTH) ? 14 : 0;
      out_stall_i <= ($urandom_range(99) < pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // entered and left at a falling edge
  task automatic send_tick(input in_t beat);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 82 : (idle_mode == IDLE_BOTH) ? 14 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(beat);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] half, trail, tmo, divr, offs);
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_TRAIL, trail);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_DIVIDER, divr);
    write_reg(CFG_SUM_OFFSET, offs);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Next tick as a converter would present it, steered by the predicted phase:
  // mostly clean conversions, with random pins where the core ignores them and
  // random data-ready delays that run into the timeout.
  function automatic in_t make_tick();
    in_t b;
    int  t;
    b.tare_request = ($urandom_range(399) == 0);
    b.data_pin     = 1'($urandom_range(1));
    if (sb.phase == PH_WAIT) begin
      if (wait_left > 0) begin
        b.data_pin = 1'b1;
        wait_left--;
      end else begin
        b.data_pin = 1'b0;
        case ($urandom_range(9))
          0: conv_word = 24'h800000;   // reads as zero
          1: conv_word = 24'h7FFFFF;   // full scale
          2: conv_word = 24'h000000;
          3: conv_word = 24'hFFFFFF;
          4, 5: conv_word = (sb.tare_base + WEIGHT_W'($urandom_range(3 * sb.divider)))
                            ^ 24'h800000;
          default: conv_word = WEIGHT_W'($urandom);
        endcase
        t = int'(sb.timeout_ticks);
        case ($urandom_range(9))
          0, 1: wait_left = $urandom_range(6, 1);
          2: wait_left = (t < 64) ? $urandom_range(3 * t + 2, t) : $urandom_range(30, 1);
          default: wait_left = 0;
        endcase
      end
    end else if (sb.phase == PH_LOW) begin
      b.data_pin = conv_word[SAMPLE_BITS_DEF - 1 - sb.bit_cnt];
    end
    return b;
  endfunction

  task automatic run_phase(input int min_items, input int min_averages);
    int n;
    n = 0;
    while ((n < min_items || sb.weights + sb.tares < min_averages)
           && items_sent < ITEMS_CAP) begin
      idle_mode = idle_mode_e'((items_sent / 100) % 4);
      send_tick(make_tick());
      n++;
    end
    settle();
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_HALF_PERIOD;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    idle_mode     = IDLE_NONE;
    hold_off      = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    conv_word     = 24'h7FFFFF;
    wait_left     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: long wait without timeout, a tare request, start of a read
    repeat (3) send_tick(in_t'{1'b1, 1'b0});
    send_tick(in_t'{1'b1, 1'b1});
    send_tick(in_t'{1'b0, 1'b0});
    send_tick(in_t'{1'b1, 1'b0});
    send_tick(in_t'{1'b0, 1'b1});
    settle();

    // all-zero registers: counts act as one, every data-high wait times out
    program_regs(0, 0, 0, 0, 0);
    send_tick(in_t'{1'b1, 1'b0});
    send_tick(in_t'{1'b1, 1'b1});
    send_tick(in_t'{1'b1, 1'b0});
    send_tick(in_t'{1'b0, 1'b0});
    repeat (4) send_tick(in_t'{1'b1, 1'b0});
    repeat (4) send_tick(in_t'{1'b0, 1'b0});
    settle();

    program_regs(1, 1, 12, 1, 0);
    hold_off = 1'b1;   // fills the core while the sender keeps offering
    run_phase(300, 0);
    program_regs(2, 1, 24'hFFFFFF, 80, 5000);
    run_phase(200, 0);
    program_regs(0, 0, 0, 0, CFG_DATA_W'($urandom_range(268435455)));
    run_phase(250, 0);
    program_regs(1023, 1023, 1, 65535, 28'hFFFFFFF);
    run_phase(120, 0);
    program_regs(1, 1, CFG_DATA_W'($urandom_range(40, 2)),
                 CFG_DATA_W'($urandom_range(500, 1)),
                 CFG_DATA_W'($urandom_range(1048575)));
    run_phase(300, 0);
    program_regs(1, 2, 5, 65535, 0);
    run_phase(250, 0);
    program_regs(2, 1, CFG_DATA_W'($urandom_range(60, 1)),
                 CFG_DATA_W'($urandom_range(20, 1)),
                 CFG_DATA_W'($urandom_range(268435455)));
    run_phase(200, 0);
    program_regs(1, 1, 30, CFG_DATA_W'($urandom_range(8, 1)),
                 CFG_DATA_W'($urandom_range(16777215)));
    run_phase(ITEMS_TARGET - items_sent, 0);

    $display("Covered %0d ticks under %0d register settings: %0d conversions, %0d timeouts,",
             sb.ticks_seen, settings_used, sb.conversions, sb.timeouts);
    $display("%0d weights and %0d tare averages, every output beat checked.",
             sb.weights, sb.tares);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lcta_pkg.sv
hdl/lcta_div.sv
hdl/lcta_datapath.sv
hdl/lcta_ctrl.sv
hdl/load_cell_adc_tare_averager_core.sv
hdl/lcta_chk.sv
tb/tb_load_cell_adc_tare_averager_core.sv
